// ----- rtl/tristate_ook_remote_encoder_core_macros.svh -----
// Assertion macros for the tri-state OOK remote encoder.
// Included by the checker module; depends on a clk and rst_n in scope.
`ifndef TRISTATE_OOK_REMOTE_ENCODER_CORE_MACROS_SVH
`define TRISTATE_OOK_REMOTE_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TORE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tore assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TORE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tore assertion failed");

`endif

// ----- rtl/tore_pkg.sv -----
// Shared types and constants for the tri-state OOK remote encoder.
// No dependencies; imported by every module of the block.
package tore_pkg;

    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
    localparam logic [2:0] STATUS_BAD_ADDR = 3'd2;
    localparam logic [2:0] STATUS_BAD_CHAN = 3'd3;
    localparam logic [2:0] STATUS_BAD_STATE = 3'd4;
    localparam logic [2:0] STATUS_BUSY     = 3'd5;

    localparam logic [3:0]  SYMBOLS          = 4'd12;
    localparam logic [4:0]  SYNC_LOW_UNITS   = 5'd31;
    localparam logic [15:0] PULSE_TICKS_RST  = 16'd350;
    localparam logic [7:0]  REPEAT_COUNT_RST = 8'd10;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SUBMIT = 1'b1;

    localparam logic REG_PULSE_TICKS  = 1'b0;
    localparam logic REG_REPEAT_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] state_char;
        logic [7:0] channel_char;
        logic [7:0] addr_char_4;
        logic [7:0] addr_char_3;
        logic [7:0] addr_char_2;
        logic [7:0] addr_char_1;
        logic [7:0] addr_char_0;
    } tore_chars_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] word;
    } tore_decode_t;

    typedef struct packed {
        logic       done_res;
        logic [2:0] status;
        logic       busy_res;
        logic       tx_level;
    } tore_result_t;

endpackage

// ----- rtl/tore_cmd_decode.sv -----
// Command checker and code word builder for the tri-state OOK remote encoder.
// Purely combinational; depends on tore_pkg.
module tore_cmd_decode
(
    input  tore_pkg::tore_chars_t  chars,
    output tore_pkg::tore_decode_t decode
);
    import tore_pkg::*;

    logic [7:0] addr [5];
    logic       addr_ok;
    logic [9:0] addr_bits;
    logic       chan_ok;
    logic [1:0] chan_sel;
    logic [9:0] chan_bits;
    logic       state_ok;
    logic [3:0] state_bits;

    assign addr[0] = chars.addr_char_0;
    assign addr[1] = chars.addr_char_1;
    assign addr[2] = chars.addr_char_2;
    assign addr[3] = chars.addr_char_3;
    assign addr[4] = chars.addr_char_4;

    // Address '0' is symbol F (pair bits 01), '1' is symbol 0 (pair bits 00).
    always_comb
    begin
        addr_ok   = 1'b1;
        addr_bits = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (addr[i] == 8'h30)
            begin
                addr_bits[9 - 2 * i -: 2] = 2'b01;
            end
            else if (addr[i] != 8'h31)
            begin
                addr_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        chan_ok  = 1'b1;
        chan_sel = '0;
        if (chars.channel_char >= 8'h41 && chars.channel_char <= 8'h44)
        begin
            chan_sel = 2'(chars.channel_char - 8'h41);
        end
        else if (chars.channel_char >= 8'h31 && chars.channel_char <= 8'h34)
        begin
            chan_sel = 2'(chars.channel_char - 8'h31);
        end
        else
        begin
            chan_ok = 1'b0;
        end
        for (int i = 0; i < 5; i++)
        begin
            chan_bits[9 - 2 * i -: 2] = (i == int'(chan_sel)) ? 2'b00 : 2'b01;
        end
    end

    always_comb
    begin
        state_ok   = 1'b1;
        state_bits = 4'b0000;
        if (chars.state_char == 8'h31)
        begin
            state_bits = 4'b0001;
        end
        else if (chars.state_char == 8'h30)
        begin
            state_bits = 4'b0100;
        end
        else
        begin
            state_ok = 1'b0;
        end
    end

    always_comb
    begin
        decode.word = {addr_bits, chan_bits, state_bits};
        if (!addr_ok)
        begin
            decode.status = STATUS_BAD_ADDR;
        end
        else if (!chan_ok)
        begin
            decode.status = STATUS_BAD_CHAN;
        end
        else if (!state_ok)
        begin
            decode.status = STATUS_BAD_STATE;
        end
        else
        begin
            decode.status = STATUS_ACCEPTED;
        end
    end

endmodule

// ----- rtl/tore_tx_engine.sv -----
// Transmission state and pulse timing for the tri-state OOK remote encoder.
// Advances one request per step; depends on tore_pkg.
module tore_tx_engine
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   cmd,
    input  tore_pkg::tore_decode_t decode,
    input  logic [15:0]            pulse_ticks,
    input  logic [7:0]             repeat_count,
    output tore_pkg::tore_result_t result
);
    import tore_pkg::*;

    logic [23:0] code_word_reg, code_word_next;
    logic [7:0]  repeats_left_reg, repeats_left_next;
    logic [3:0]  symbol_index_reg, symbol_index_next;
    logic        pulse_half_reg, pulse_half_next;
    logic        phase_high_reg, phase_high_next;
    logic        in_sync_reg, in_sync_next;
    logic [4:0]  units_left_reg, units_left_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic        active_reg, active_next;

    logic [15:0] unit_len;
    logic [7:0]  repeats_dec;
    logic [3:0]  symbol_inc;
    logic        start_high;

    function automatic logic pair_bit(logic [23:0] word, logic [3:0] sym, logic half);
        logic [4:0] idx;
        idx = {sym, half};
        if (idx > 5'd23)
        begin
            return 1'b0;
        end
        return word[5'd23 - idx];
    endfunction

    assign unit_len    = (pulse_ticks == 16'd0) ? 16'd1 : pulse_ticks;
    assign repeats_dec = repeats_left_reg - 8'd1;
    assign symbol_inc  = symbol_index_reg + 4'd1;

    always_comb
    begin
        code_word_next    = code_word_reg;
        repeats_left_next = repeats_left_reg;
        symbol_index_next = symbol_index_reg;
        pulse_half_next   = pulse_half_reg;
        phase_high_next   = phase_high_reg;
        in_sync_next      = in_sync_reg;
        units_left_next   = units_left_reg;
        ticks_left_next   = ticks_left_reg;
        active_next       = active_reg;
        start_high        = 1'b0;

        result.tx_level = active_reg & phase_high_reg;
        result.busy_res = active_reg;
        result.status   = STATUS_NONE;
        result.done_res = 1'b0;

        if (step)
        begin
            if (cmd == CMD_TICK)
            begin
                if (active_reg)
                begin
                    if (ticks_left_reg > 16'd1)
                    begin
                        ticks_left_next = ticks_left_reg - 16'd1;
                    end
                    else
                    begin
                        ticks_left_next = unit_len;
                        if (units_left_reg > 5'd1)
                        begin
                            units_left_next = units_left_reg - 5'd1;
                        end
                        else if (phase_high_reg)
                        begin
                            phase_high_next = 1'b0;
                            if (in_sync_reg)
                            begin
                                units_left_next = SYNC_LOW_UNITS;
                            end
                            else if (pair_bit(code_word_reg, symbol_index_reg, pulse_half_reg))
                            begin
                                units_left_next = 5'd1;
                            end
                            else
                            begin
                                units_left_next = 5'd3;
                            end
                        end
                        else if (in_sync_reg)
                        begin
                            repeats_left_next = repeats_dec;
                            if (repeats_dec == 8'd0)
                            begin
                                active_next     = 1'b0;
                                phase_high_next = 1'b0;
                                in_sync_next    = 1'b0;
                                units_left_next = '0;
                                ticks_left_next = '0;
                                result.done_res = 1'b1;
                            end
                            else
                            begin
                                in_sync_next      = 1'b0;
                                symbol_index_next = '0;
                                pulse_half_next   = 1'b0;
                                start_high        = 1'b1;
                            end
                        end
                        else if (!pulse_half_reg)
                        begin
                            pulse_half_next = 1'b1;
                            start_high      = 1'b1;
                        end
                        else
                        begin
                            pulse_half_next = 1'b0;
                            if (symbol_inc >= SYMBOLS)
                            begin
                                symbol_index_next = '0;
                                in_sync_next      = 1'b1;
                            end
                            else
                            begin
                                symbol_index_next = symbol_inc;
                            end
                            start_high = 1'b1;
                        end
                    end
                end
            end
            else if (active_reg)
            begin
                result.status = STATUS_BUSY;
            end
            else
            begin
                result.status = decode.status;
                if (decode.status == STATUS_ACCEPTED)
                begin
                    code_word_next    = decode.word;
                    repeats_left_next = repeat_count;
                    symbol_index_next = '0;
                    pulse_half_next   = 1'b0;
                    in_sync_next      = 1'b0;
                    if (repeat_count != 8'd0)
                    begin
                        active_next     = 1'b1;
                        phase_high_next = 1'b1;
                        units_left_next = decode.word[23] ? 5'd3 : 5'd1;
                        ticks_left_next = unit_len;
                    end
                end
            end
        end

        if (start_high)
        begin
            phase_high_next = 1'b1;
            ticks_left_next = unit_len;
            if (in_sync_next)
            begin
                units_left_next = 5'd1;
            end
            else if (pair_bit(code_word_reg, symbol_index_next, pulse_half_next))
            begin
                units_left_next = 5'd3;
            end
            else
            begin
                units_left_next = 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_word_reg    <= '0;
            repeats_left_reg <= '0;
            symbol_index_reg <= '0;
            pulse_half_reg   <= 1'b0;
            phase_high_reg   <= 1'b0;
            in_sync_reg      <= 1'b0;
            units_left_reg   <= '0;
            ticks_left_reg   <= '0;
            active_reg       <= 1'b0;
        end
        else
        begin
            code_word_reg    <= code_word_next;
            repeats_left_reg <= repeats_left_next;
            symbol_index_reg <= symbol_index_next;
            pulse_half_reg   <= pulse_half_next;
            phase_high_reg   <= phase_high_next;
            in_sync_reg      <= in_sync_next;
            units_left_reg   <= units_left_next;
            ticks_left_reg   <= ticks_left_next;
            active_reg       <= active_next;
        end
    end

endmodule

// ----- rtl/tristate_ook_remote_encoder_core.sv -----
// Tri-state OOK remote switch encoder: takes one request per clock cycle when the output side
// is not stalled, either a time tick or a seven-character switch command, and returns one
// result per request. Each request passes an input register and then a result register
// before its result is presented on the output; the throughput of one request per cycle
// is set by the single pass through the transmit state update between those two registers.
// Depends on tore_pkg, tore_cmd_decode and tore_tx_engine.
module tristate_ook_remote_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // addr_char_0..4, channel_char, state_char
    input  logic        s_tuser,   // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_level, busy_res, status[2:0], done_res, zero pad

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tore_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic         in_cmd_reg;
    tore_chars_t  in_chars_reg;
    logic         out_valid_reg, out_valid_next;
    tore_result_t out_result_reg;
    logic [15:0]  pulse_ticks_reg;
    logic [7:0]   repeat_count_reg;

    logic         advance;
    logic         cfg_write;
    tore_decode_t decode;
    tore_result_t result;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_REPEAT_COUNT) ? {24'd0, repeat_count_reg}
                                                      : {16'd0, pulse_ticks_reg};

    tore_cmd_decode u_decode
    (
        .chars  (in_chars_reg),
        .decode (decode)
    );

    tore_tx_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .cmd          (in_cmd_reg),
        .decode       (decode),
        .pulse_ticks  (pulse_ticks_reg),
        .repeat_count (repeat_count_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pulse_ticks_reg  <= PULSE_TICKS_RST;
            repeat_count_reg <= REPEAT_COUNT_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_REPEAT_COUNT)
                begin
                    repeat_count_reg <= pwdata[7:0];
                end
                else
                begin
                    pulse_ticks_reg <= pwdata[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_chars_reg <= tore_chars_t'(s_tdata);
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

endmodule

// ----- rtl/tore_checker.sv -----
// Port-level checks on the results of the tri-state OOK remote encoder.
// Depends on tore_pkg and the assertion macros header; bound to the top level.
`include "tristate_ook_remote_encoder_core_macros.svh"

module tore_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import tore_pkg::*;

    logic       tx_level;
    logic       busy_res;
    logic [2:0] status;
    logic       done_res;

    assign tx_level = m_tdata[0];
    assign busy_res = m_tdata[1];
    assign status   = m_tdata[4:2];
    assign done_res = m_tdata[5];

    `TORE_ASSERT_NOW(a_status_code, m_tvalid, status <= STATUS_BUSY)
    `TORE_ASSERT_NOW(a_done_while_busy, m_tvalid && done_res, busy_res && status == STATUS_NONE)
    `TORE_ASSERT_NOW(a_idle_pin_low, m_tvalid && !busy_res, !tx_level && !done_res)
    `TORE_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tristate_ook_remote_encoder_core tore_checker u_tore_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_tristate_ook_remote_encoder_core.sv -----
// Self-checking testbench for tristate_ook_remote_encoder_core: directed command checks and
// transmissions, then random stream traffic under several idle and stall patterns.
// Depends on tore_pkg and the core; a built-in encoder model predicts every result.
module tb_tristate_ook_remote_encoder_core;
    import tore_pkg::*;

    typedef enum int {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pacing_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int OUTPUT_LATENCY = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = CMD_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Encoder model: configuration and transmit state as seen after each accepted request.
    logic [15:0] cfg_pulse_ticks = PULSE_TICKS_RST;
    logic [7:0]  cfg_repeat_count = REPEAT_COUNT_RST;
    logic [23:0] tx_word = '0;
    logic [7:0]  frames_left = '0;
    logic [3:0]  sym_pos = '0;
    logic        pair_half = 1'b0;
    logic        level_high = 1'b0;
    logic        sync_pair = 1'b0;
    logic [4:0]  units_remaining = '0;
    logic [15:0] ticks_remaining = '0;
    logic        tx_active = 1'b0;

    tore_result_t predicted_outputs[$];
    int failures = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    tristate_ook_remote_encoder_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] unit_ticks();
        return (cfg_pulse_ticks == 16'd0) ? 16'd1 : cfg_pulse_ticks;
    endfunction

    function automatic logic long_high_pair();
        int pos;
        pos = 23 - (2 * int'(sym_pos) + int'(pair_half));
        return tx_word[pos];
    endfunction

    function automatic void load_high_phase();
        level_high = 1'b1;
        units_remaining = sync_pair ? 5'd1 : (long_high_pair() ? 5'd3 : 5'd1);
        ticks_remaining = unit_ticks();
    endfunction

    function automatic logic close_pair();
        if (sync_pair)
        begin
            frames_left = frames_left - 8'd1;
            if (frames_left == 8'd0)
            begin
                tx_active = 1'b0;
                level_high = 1'b0;
                sync_pair = 1'b0;
                units_remaining = '0;
                ticks_remaining = '0;
                return 1'b1;
            end
            sync_pair = 1'b0;
            sym_pos = '0;
            pair_half = 1'b0;
        end
        else if (!pair_half)
        begin
            pair_half = 1'b1;
        end
        else
        begin
            pair_half = 1'b0;
            sym_pos = sym_pos + 4'd1;
            if (sym_pos >= SYMBOLS)
            begin
                sym_pos = '0;
                sync_pair = 1'b1;
            end
        end
        load_high_phase();
        return 1'b0;
    endfunction

    function automatic logic advance_one_tick();
        if (ticks_remaining > 16'd1)
        begin
            ticks_remaining = ticks_remaining - 16'd1;
            return 1'b0;
        end
        ticks_remaining = unit_ticks();
        if (units_remaining > 5'd1)
        begin
            units_remaining = units_remaining - 5'd1;
            return 1'b0;
        end
        if (level_high)
        begin
            level_high = 1'b0;
            units_remaining = sync_pair ? SYNC_LOW_UNITS : (long_high_pair() ? 5'd1 : 5'd3);
            return 1'b0;
        end
        return close_pair();
    endfunction

    // Address '0' is symbol F (pair bits 01), '1' is symbol 0 (00); the channel is a one-hot
    // 0 among five symbols and the state adds 0F or F0.
    function automatic tore_result_t encode_request(input logic cmd, input tore_chars_t chars);
        tore_result_t r;
        logic [23:0] word;
        logic [7:0] c;
        int ch;
        int i;
        r.tx_level = tx_active ? level_high : 1'b0;
        r.busy_res = tx_active;
        r.status = STATUS_NONE;
        r.done_res = 1'b0;
        word = '0;
        ch = 0;
        if (cmd == CMD_TICK)
        begin
            if (tx_active)
                r.done_res = advance_one_tick();
        end
        else if (tx_active)
        begin
            r.status = STATUS_BUSY;
        end
        else
        begin
            r.status = STATUS_ACCEPTED;
            for (i = 0; i < 5 && r.status == STATUS_ACCEPTED; i++)
            begin
                c = chars[8*i +: 8];
                if (c == "0")
                    word = {word[21:0], 2'b01};
                else if (c == "1")
                    word = {word[21:0], 2'b00};
                else
                    r.status = STATUS_BAD_ADDR;
            end
            if (r.status == STATUS_ACCEPTED)
            begin
                c = chars.channel_char;
                if (c >= "A" && c <= "D")
                    ch = int'(c) - int'("A");
                else if (c >= "1" && c <= "4")
                    ch = int'(c) - int'("1");
                else
                    r.status = STATUS_BAD_CHAN;
            end
            if (r.status == STATUS_ACCEPTED)
            begin
                for (i = 0; i < 5; i++)
                    word = {word[21:0], (i == ch) ? 2'b00 : 2'b01};
                c = chars.state_char;
                if (c == "1")
                    word = {word[19:0], 4'b0001};
                else if (c == "0")
                    word = {word[19:0], 4'b0100};
                else
                    r.status = STATUS_BAD_STATE;
            end
            if (r.status == STATUS_ACCEPTED)
            begin
                tx_word = word;
                frames_left = cfg_repeat_count;
                sym_pos = '0;
                pair_half = 1'b0;
                sync_pair = 1'b0;
                if (frames_left != 8'd0)
                begin
                    tx_active = 1'b1;
                    load_high_phase();
                end
            end
        end
        return r;
    endfunction

    function automatic tore_chars_t command_chars(input logic [39:0] addr, input logic [7:0] chan,
                                                  input logic [7:0] st);
        tore_chars_t c;
        int i;
        for (i = 0; i < 5; i++)
            c[8*i +: 8] = addr[39 - 8*i -: 8];
        c.channel_char = chan;
        c.state_char = st;
        return c;
    endfunction

    function automatic tore_chars_t random_chars(input int valid_pct);
        tore_chars_t c;
        logic [63:0] raw;
        logic well_formed;
        string chan_set;
        int i;
        chan_set = "ABCD1234";
        raw = {$urandom(), $urandom()};
        c = raw[55:0];
        well_formed = ($urandom_range(99) < valid_pct);
        for (i = 0; i < 5; i++)
            if (well_formed || $urandom_range(1))
                c[8*i +: 8] = $urandom_range(1) ? "1" : "0";
        if (well_formed || $urandom_range(1))
            c.channel_char = chan_set[$urandom_range(7)];
        if (well_formed || $urandom_range(1))
            c.state_char = $urandom_range(1) ? "1" : "0";
        return c;
    endfunction

    task automatic set_pacing(input pacing_t mode);
        sender_idle_pct = (mode == PACE_SENDER_GAPS) ? 60 : (mode == PACE_BOTH) ? 27 : 0;
        receiver_stall_pct = (mode == PACE_RECEIVER_STALLS) ? 60 : (mode == PACE_BOTH) ? 27 : 0;
    endtask

    task automatic send_request(input logic cmd, input tore_chars_t chars);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = chars;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted_outputs.push_back(encode_request(cmd, chars));
    endtask

    task automatic submit_command(input logic [39:0] addr, input logic [7:0] chan,
                                  input logic [7:0] st);
        send_request(CMD_SUBMIT, command_chars(addr, chan, st));
    endtask

    task automatic tick_until_idle();
        while (tx_active)
            send_request(CMD_TICK, random_chars(0));
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (OUTPUT_LATENCY + 2) @(posedge clk);
    endtask

    // Writes a register with random upper data bits, then reads it back.
    task automatic write_register(input logic reg_sel, input logic [15:0] value);
        logic [31:0] wdata;
        logic [31:0] stored;
        wdata = $urandom();
        if (reg_sel == REG_PULSE_TICKS)
        begin
            wdata[15:0] = value;
            stored = {16'd0, value};
        end
        else
        begin
            wdata[7:0] = value[7:0];
            stored = {24'd0, value[7:0]};
        end
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_sel, 2'b00};
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_PULSE_TICKS)
            cfg_pulse_ticks = value;
        else
            cfg_repeat_count = value[7:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== stored)
        begin
            failures++;
            $display("%0t register %0d read expected %h got %h", $time, reg_sel, stored, prdata);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // With no repeats every valid command is accepted without starting a transmission.
    task automatic test_command_checks();
        set_pacing(PACE_STEADY);
        write_register(REG_PULSE_TICKS, 16'd1);
        write_register(REG_REPEAT_COUNT, 16'd0);
        send_request(CMD_TICK, random_chars(0));
        submit_command("01101", "A", "1");
        submit_command("11111", "D", "0");
        submit_command("00000", "1", "1");
        submit_command("10101", "4", "0");
        submit_command("00110", "B", "1");
        submit_command("11001", "C", "0");
        submit_command("01010", "2", "1");
        submit_command("10100", "3", "0");
        submit_command({8'h00, "1111"}, "A", "1");
        submit_command({"1111", 8'hFF}, "A", "1");
        submit_command("01201", "B", "0");
        submit_command("1/000", "C", "1");
        submit_command("01101", "@", "1");
        submit_command("01101", "E", "1");
        submit_command("01101", "0", "0");
        submit_command("01101", "5", "1");
        submit_command("01101", 8'hFF, "0");
        submit_command("01101", "A", "2");
        submit_command("01101", "D", 8'h00);
        submit_command("01201", "E", "2");
        submit_command("01101", "E", "2");
        send_request(CMD_TICK, {7{8'hFF}});
        drain_outputs();
    endtask

    // Busy submits, and a repeat count change part-way through a transmission.
    task automatic test_transmission();
        set_pacing(PACE_STEADY);
        write_register(REG_PULSE_TICKS, 16'd1);
        write_register(REG_REPEAT_COUNT, 16'd2);
        submit_command("10110", "C", "1");
        repeat (20) send_request(CMD_TICK, random_chars(0));
        submit_command("00000", "A", "0");
        submit_command("0120 ", "Z", "9");
        drain_outputs();
        write_register(REG_REPEAT_COUNT, 16'd1);
        tick_until_idle();
        drain_outputs();
    endtask

    // The widest pulse length is stored and read back; part-way through a long unit the pulse
    // length is then changed, which only applies from the next unit.
    task automatic test_long_unit();
        set_pacing(PACE_STEADY);
        write_register(REG_PULSE_TICKS, 16'hFFFF);
        write_register(REG_PULSE_TICKS, 16'd40);
        write_register(REG_REPEAT_COUNT, 16'd1);
        submit_command("11100", "B", "1");
        repeat (20) send_request(CMD_TICK, random_chars(0));
        drain_outputs();
        write_register(REG_PULSE_TICKS, 16'd1);
        tick_until_idle();
        drain_outputs();
    endtask

    // A zero pulse length runs as one tick per unit; the largest repeat count is stored.
    task automatic test_zero_pulse();
        set_pacing(PACE_STEADY);
        write_register(REG_PULSE_TICKS, 16'd0);
        write_register(REG_REPEAT_COUNT, 16'd255);
        write_register(REG_REPEAT_COUNT, 16'd1);
        submit_command("00111", "2", "0");
        tick_until_idle();
        drain_outputs();
    endtask

    task automatic test_random_traffic(input pacing_t mode, input int request_budget);
        int counted;
        set_pacing(mode);
        write_register(REG_PULSE_TICKS, 16'($urandom_range(1)));
        write_register(REG_REPEAT_COUNT,
                       ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(2, 1)));
        counted = 0;
        while (counted < request_budget)
        begin
            if (!tx_active)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_request(CMD_TICK, random_chars(0));
                end
                else
                begin
                    send_request(CMD_SUBMIT, random_chars(80));
                    counted++;
                end
            end
            else
            begin
                if ($urandom_range(19) == 0)
                    send_request(CMD_SUBMIT, random_chars(50));
                else
                    send_request(CMD_TICK, random_chars(0));
                counted++;
            end
        end
        drain_outputs();
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_field(input string field, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $display("%0t %s expected %0d got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        tore_result_t got;
        tore_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[5:0];
            if (predicted_outputs.size() == 0)
            begin
                failures++;
                $display("%0t unexpected result expected none got %h", $time, m_tdata);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                report_field("tx_level", want.tx_level, got.tx_level);
                report_field("busy_res", want.busy_res, got.busy_res);
                report_field("status", want.status, got.status);
                report_field("done_res", want.done_res, got.done_res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL tristate_ook_remote_encoder_core");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_command_checks();
        test_transmission();
        test_long_unit();
        test_zero_pulse();
        test_random_traffic(PACE_STEADY, 50);
        test_random_traffic(PACE_SENDER_GAPS, 50);
        test_random_traffic(PACE_RECEIVER_STALLS, 50);
        test_random_traffic(PACE_BOTH, 50);
        tick_until_idle();
        drain_outputs();
        repeat (10) @(posedge clk);
        if (failures == 0 && predicted_outputs.size() == 0)
            $display("PASS tristate_ook_remote_encoder_core");
        else
            $display("FAIL tristate_ook_remote_encoder_core");
        $finish;
    end

endmodule
